[sv/qslerp_pkg.sv]
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared widths, angle constants and the arctangent table of the quaternion
// slerp pipeline.
// ----------------------------------------------------------------------------
package qslerp_pkg;

   // cordic
   localparam int CORDIC_STEPS = 14;
   localparam int XY_W         = 34;
   localparam int Z_W          = 18;
   localparam int ANGLE_W      = 15;
   localparam int ATAN_W       = 13;

   // square root
   localparam int SQRT_IN_W = 62;
   localparam int ROOT_W    = 31;
   localparam int REM_W     = 33;

   // misc
   localparam int SINE_W  = 32;
   localparam int BLEND_W = 17;

   localparam logic [ANGLE_W-1:0]   HALF_PI_Q13     = 15'd12868;
   localparam logic [ANGLE_W-1:0]   PI_Q13          = 15'd25736;
   localparam logic [BLEND_W-1:0]   BLEND_ONE       = 17'd65536;
   localparam logic signed [XY_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;
   localparam logic [SQRT_IN_W-1:0] ONE_Q60         = {2'b01, 60'd0};

   // atan(2^-i) in unsigned Q0.13
   localparam logic [ATAN_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      13'd6434, 13'd3798, 13'd2007, 13'd1019, 13'd511, 13'd256, 13'd128,
      13'd64, 13'd32, 13'd16, 13'd8, 13'd4, 13'd2, 13'd1
   };

   typedef logic signed [XY_W-1:0] xy_type;
   typedef logic signed [Z_W-1:0]  z_type;
   typedef logic [ANGLE_W-1:0]     angle_type;
   typedef logic [SQRT_IN_W-1:0]   radicand_type;
   typedef logic [ROOT_W-1:0]      root_type;
   typedef logic [REM_W-1:0]       rem_type;

endpackage

[sv/qslerp_delay.sv]
// ----------------------------------------------------------------------------
// qslerp_delay
// Enabled shift line that carries side data alongside a chain of cells.
// ----------------------------------------------------------------------------
module qslerp_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] src_data,
   output logic [W-1:0] dst_data
);

   logic [W-1:0] line_ff [DEPTH];

   // shift on advance
   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= src_data;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dst_data = line_ff[DEPTH-1];

endmodule

[sv/qslerp_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// qslerp_sqrt_cell
// One digit of a restoring integer square root: two radicand bits in, one
// root bit out.
// ----------------------------------------------------------------------------
module qslerp_sqrt_cell (
   input  logic                     clock,
   input  logic                     en,
   input  qslerp_pkg::radicand_type src_rad,
   input  qslerp_pkg::rem_type      src_rem,
   input  qslerp_pkg::root_type     src_root,
   output qslerp_pkg::radicand_type dst_rad,
   output qslerp_pkg::rem_type      dst_rem,
   output qslerp_pkg::root_type     dst_root
);
   import qslerp_pkg::*;

   logic [REM_W+1:0] part;
   logic [REM_W+1:0] trial;
   logic             fits;
   radicand_type     rad_ff, rad_in;
   rem_type          rem_ff, rem_in;
   root_type         root_ff, root_in;

   // trial subtract of the next root bit
   always_comb begin
      part    = {src_rem, src_rad[SQRT_IN_W-1 -: 2]};
      trial   = {2'b00, src_root, 2'b01};
      fits    = part >= trial;
      rem_in  = fits ? REM_W'(part - trial) : REM_W'(part);
      root_in = {src_root[ROOT_W-2:0], fits};
      rad_in  = {src_rad[SQRT_IN_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign dst_rad  = rad_ff;
   assign dst_rem  = rem_ff;
   assign dst_root = root_ff;

endmodule

[sv/qslerp_cordic_cell.sv]
// ----------------------------------------------------------------------------
// qslerp_cordic_cell
// One micro-rotation of a CORDIC, steered by y (vectoring) or by z
// (rotation).
// ----------------------------------------------------------------------------
module qslerp_cordic_cell #(
   parameter int INDEX  = 0,
   parameter bit VECTOR = 1'b0
) (
   input  logic               clock,
   input  logic               en,
   input  qslerp_pkg::xy_type src_x,
   input  qslerp_pkg::xy_type src_y,
   input  qslerp_pkg::z_type  src_z,
   output qslerp_pkg::xy_type dst_x,
   output qslerp_pkg::xy_type dst_y,
   output qslerp_pkg::z_type  dst_z
);
   import qslerp_pkg::*;

   xy_type xs, ys;
   z_type  step;
   logic   pos;
   xy_type x_ff, x_in, y_ff, y_in;
   z_type  z_ff, z_in;

   // positive turn: x -= y', y += x', z -= atan
   always_comb begin
      xs   = src_x >>> INDEX;
      ys   = src_y >>> INDEX;
      step = Z_W'(ATAN_TABLE[INDEX]);
      pos  = VECTOR ? src_y[XY_W-1] : !src_z[Z_W-1];
      if (pos) begin
         x_in = src_x - ys;
         y_in = src_y + xs;
         z_in = src_z - step;
      end else begin
         x_in = src_x + ys;
         y_in = src_y - xs;
         z_in = src_z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign dst_x = x_ff;
   assign dst_y = y_ff;
   assign dst_z = z_ff;

endmodule

[sv/qslerp_div_cell.sv]
// ----------------------------------------------------------------------------
// qslerp_div_cell
// One quotient bit of a restoring divide, for all four components at once.
// ----------------------------------------------------------------------------
module qslerp_div_cell #(
   parameter int COMP_W  = 16,
   parameter int NUM_W   = 51,
   parameter int BIT_POS = 0
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [3:0][NUM_W-1:0]       src_rem,
   input  logic [3:0][COMP_W-1:0]      src_q,
   input  qslerp_pkg::root_type        src_s,
   output logic [3:0][NUM_W-1:0]       dst_rem,
   output logic [3:0][COMP_W-1:0]      dst_q,
   output qslerp_pkg::root_type        dst_s
);
   import qslerp_pkg::*;

   logic [NUM_W-1:0]         divisor;
   logic [3:0][NUM_W-1:0]    rem_ff, rem_in;
   logic [3:0][COMP_W-1:0]   q_ff, q_in;
   root_type                 s_ff;

   // compare against the shifted divisor
   always_comb begin
      divisor = NUM_W'(src_s) << BIT_POS;
      for (int k = 0; k < 4; k++) begin
         if (src_rem[k] >= divisor) begin
            rem_in[k] = src_rem[k] - divisor;
            q_in[k]   = src_q[k] | (COMP_W'(1) << BIT_POS);
         end else begin
            rem_in[k] = src_rem[k];
            q_in[k]   = src_q[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
         s_ff   <= src_s;
      end
   end

   assign dst_rem = rem_ff;
   assign dst_q   = q_ff;
   assign dst_s   = s_ff;

endmodule

[sv/quaternion_slerp_top.sv]
// ----------------------------------------------------------------------------
// quaternion_slerp_top
// Fixed-point quaternion slerp, fully pipelined through rows of cells.
// ----------------------------------------------------------------------------
// Takes one beat per clock while no result waits on a stalled result side,
// and returns one result beat per beat, in order. The pipeline is made of the
// cell rows: 31 square-root digit cells, 14 vectoring CORDIC
// cells, 14 rotation CORDIC cells (two rows side by side for the two sines),
// COMPONENT_BITS divide cells, and eight single stages for products, sums,
// angle scaling and output. A stall on the result side holds the whole
// pipeline, and stalls the input side, only while a result waits.
// Degenerate dot products (|qr| >= 1) return the start quaternion with
// passed_through set.
module quaternion_slerp_top #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [COMPONENT_BITS-1:0] req_from_x,
   input  logic signed [COMPONENT_BITS-1:0] req_from_y,
   input  logic signed [COMPONENT_BITS-1:0] req_from_z,
   input  logic signed [COMPONENT_BITS-1:0] req_from_w,
   input  logic signed [COMPONENT_BITS-1:0] req_to_x,
   input  logic signed [COMPONENT_BITS-1:0] req_to_y,
   input  logic signed [COMPONENT_BITS-1:0] req_to_z,
   input  logic signed [COMPONENT_BITS-1:0] req_to_w,
   input  logic [qslerp_pkg::BLEND_W-1:0]   req_blend,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [COMPONENT_BITS-1:0] rsp_out_x,
   output logic signed [COMPONENT_BITS-1:0] rsp_out_y,
   output logic signed [COMPONENT_BITS-1:0] rsp_out_z,
   output logic signed [COMPONENT_BITS-1:0] rsp_out_w,
   output logic                             rsp_passed_through
);
   import qslerp_pkg::*;

   localparam int CW      = COMPONENT_BITS;
   localparam int PROD_W  = 2 * CW;
   localparam int MUL_W   = CW + SINE_W + 1;
   localparam int SUM_W   = MUL_W + 1;
   localparam int NUM_W   = SUM_W + 1;
   localparam int LATENCY = 3 + ROOT_W + CORDIC_STEPS + 1 + CORDIC_STEPS + 3 + CW + 1;
   localparam int W1      = 8 * CW + BLEND_W + 1 + ROOT_W;
   localparam int W2      = 8 * CW + BLEND_W + 1 + ROOT_W;
   localparam int W3      = 8 * CW + 1 + ROOT_W;
   localparam int W4      = 4 * CW + 9;

   function automatic angle_type fold_angle(input angle_type a);
      return (a > HALF_PI_Q13) ? angle_type'(PI_Q13 - a) : a;
   endfunction

   // pipeline control
   logic               adv;
   logic [LATENCY-1:0] vld_ff;

   assign adv       = !(vld_ff[LATENCY-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_valid};
      end
   end

   // component products brought to Q.30
   logic [3:0][CW-1:0]        req_f, req_g;
   logic signed [PROD_W-1:0]  prod [4];
   logic [3:0][31:0]          q30;

   assign req_f = {req_from_w, req_from_z, req_from_y, req_from_x};
   assign req_g = {req_to_w, req_to_z, req_to_y, req_to_x};

   for (genvar k = 0; k < 4; k++) begin : g_prod
      assign prod[k] = PROD_W'($signed(req_f[k])) * PROD_W'($signed(req_g[k]));
      if (PROD_W > 32) begin : g_down
         assign q30[k] = 32'(prod[k] >>> (PROD_W - 32));
      end else begin : g_up
         assign q30[k] = 32'(prod[k]) << (32 - PROD_W);
      end
   end

   logic [3:0][CW-1:0]    a_f_ff, a_g_ff;
   logic [BLEND_W-1:0]    a_t_ff;
   logic [3:0][31:0]      a_p_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_f_ff <= req_f;
         a_g_ff <= req_g;
         a_t_ff <= req_blend;
         a_p_ff <= q30;
      end
   end

   // dot product
   logic [3:0][CW-1:0]    b_f_ff, b_g_ff;
   logic [BLEND_W-1:0]    b_t_ff;
   logic signed [33:0]    b_dot_ff, b_dot_in;

   assign b_dot_in = 34'($signed(a_p_ff[0])) + 34'($signed(a_p_ff[1]))
                   + 34'($signed(a_p_ff[2])) + 34'($signed(a_p_ff[3]));

   always_ff @(posedge clock) begin
      if (adv) begin
         b_f_ff   <= a_f_ff;
         b_g_ff   <= a_g_ff;
         b_t_ff   <= a_t_ff;
         b_dot_ff <= b_dot_in;
      end
   end

   // degenerate check and qr squared
   logic [3:0][CW-1:0]    c_f_ff, c_g_ff;
   logic [BLEND_W-1:0]    c_t_ff;
   logic                  c_deg_ff, c_deg_in;
   logic signed [30:0]    c_dot_ff, dot31;
   logic signed [61:0]    sq_full;
   logic [61:0]           c_sq_ff;

   assign dot31    = b_dot_ff[30:0];
   assign sq_full  = 62'(dot31) * 62'(dot31);
   assign c_deg_in = (b_dot_ff >= 34'sd1073741824) || (b_dot_ff <= -34'sd1073741824);

   always_ff @(posedge clock) begin
      if (adv) begin
         c_f_ff   <= b_f_ff;
         c_g_ff   <= b_g_ff;
         c_t_ff   <= b_t_ff;
         c_deg_ff <= c_deg_in;
         c_dot_ff <= dot31;
         c_sq_ff  <= $unsigned(sq_full);
      end
   end

   // square root row: s = sqrt(1 - qr^2)
   radicand_type sq_rad  [ROOT_W+1];
   rem_type      sq_rem  [ROOT_W+1];
   root_type     sq_root [ROOT_W+1];

   assign sq_rad[0]  = ONE_Q60 - c_sq_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      qslerp_sqrt_cell u_cell (
         .clock    (clock),
         .en       (adv),
         .src_rad  (sq_rad[i]),
         .src_rem  (sq_rem[i]),
         .src_root (sq_root[i]),
         .dst_rad  (sq_rad[i+1]),
         .dst_rem  (sq_rem[i+1]),
         .dst_root (sq_root[i+1])
      );
   end

   logic [W1-1:0]         d1_data;
   logic [3:0][CW-1:0]    d1_f, d1_g;
   logic [BLEND_W-1:0]    d1_t;
   logic                  d1_deg;
   logic signed [30:0]    d1_dot;

   qslerp_delay #(.W(W1), .DEPTH(ROOT_W)) u_delay_sqrt (
      .clock    (clock),
      .en       (adv),
      .src_data ({c_f_ff, c_g_ff, c_t_ff, c_deg_ff, c_dot_ff}),
      .dst_data (d1_data)
   );
   assign {d1_f, d1_g, d1_t, d1_deg, d1_dot} = d1_data;

   // vectoring row: phi = atan2(s, qr), quarter turn first for qr < 0
   xy_type v_x [CORDIC_STEPS+1];
   xy_type v_y [CORDIC_STEPS+1];
   z_type  v_z [CORDIC_STEPS+1];

   always_comb begin
      if (d1_dot[30]) begin
         v_x[0] = XY_W'(sq_root[ROOT_W]);
         v_y[0] = -XY_W'(d1_dot);
         v_z[0] = Z_W'(HALF_PI_Q13);
      end else begin
         v_x[0] = XY_W'(d1_dot);
         v_y[0] = XY_W'(sq_root[ROOT_W]);
         v_z[0] = '0;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vect
      qslerp_cordic_cell #(.INDEX(i), .VECTOR(1'b1)) u_cell (
         .clock (clock),
         .en    (adv),
         .src_x (v_x[i]),
         .src_y (v_y[i]),
         .src_z (v_z[i]),
         .dst_x (v_x[i+1]),
         .dst_y (v_y[i+1]),
         .dst_z (v_z[i+1])
      );
   end

   logic [W2-1:0]         d2_data;
   logic [3:0][CW-1:0]    d2_f, d2_g;
   logic [BLEND_W-1:0]    d2_t;
   logic                  d2_deg;
   root_type              d2_s;

   qslerp_delay #(.W(W2), .DEPTH(CORDIC_STEPS)) u_delay_vect (
      .clock    (clock),
      .en       (adv),
      .src_data ({d1_f, d1_g, d1_t, d1_deg, sq_root[ROOT_W]}),
      .dst_data (d2_data)
   );
   assign {d2_f, d2_g, d2_t, d2_deg, d2_s} = d2_data;

   // clamp phi and scale by t
   z_type              z_end;
   angle_type          phi;
   logic [BLEND_W-1:0] t_sat;
   logic [31:0]        phi_t;
   angle_type          p_phi_ff, p_pt_ff;
   logic [3:0][CW-1:0] p_f_ff, p_g_ff;
   logic               p_deg_ff;
   root_type           p_s_ff;

   always_comb begin
      z_end = v_z[CORDIC_STEPS];
      if (z_end[Z_W-1]) begin
         phi = '0;
      end else if (z_end > $signed(Z_W'(PI_Q13))) begin
         phi = PI_Q13;
      end else begin
         phi = z_end[ANGLE_W-1:0];
      end
      t_sat = (d2_t > BLEND_ONE) ? BLEND_ONE : d2_t;
      phi_t = 32'(phi) * 32'(t_sat) + 32'd32768;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_phi_ff <= phi;
         p_pt_ff  <= phi_t[16 +: ANGLE_W];
         p_f_ff   <= d2_f;
         p_g_ff   <= d2_g;
         p_deg_ff <= d2_deg;
         p_s_ff   <= d2_s;
      end
   end

   // rotation rows: sin(phi - phi*t) and sin(phi*t)
   xy_type r0_x [CORDIC_STEPS+1];
   xy_type r0_y [CORDIC_STEPS+1];
   z_type  r0_z [CORDIC_STEPS+1];
   xy_type r1_x [CORDIC_STEPS+1];
   xy_type r1_y [CORDIC_STEPS+1];
   z_type  r1_z [CORDIC_STEPS+1];

   assign r0_x[0] = CORDIC_INV_GAIN;
   assign r0_y[0] = '0;
   assign r0_z[0] = Z_W'(fold_angle(angle_type'(p_phi_ff - p_pt_ff)));
   assign r1_x[0] = CORDIC_INV_GAIN;
   assign r1_y[0] = '0;
   assign r1_z[0] = Z_W'(fold_angle(p_pt_ff));

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      qslerp_cordic_cell #(.INDEX(i), .VECTOR(1'b0)) u_cell0 (
         .clock (clock),
         .en    (adv),
         .src_x (r0_x[i]),
         .src_y (r0_y[i]),
         .src_z (r0_z[i]),
         .dst_x (r0_x[i+1]),
         .dst_y (r0_y[i+1]),
         .dst_z (r0_z[i+1])
      );
      qslerp_cordic_cell #(.INDEX(i), .VECTOR(1'b0)) u_cell1 (
         .clock (clock),
         .en    (adv),
         .src_x (r1_x[i]),
         .src_y (r1_y[i]),
         .src_z (r1_z[i]),
         .dst_x (r1_x[i+1]),
         .dst_y (r1_y[i+1]),
         .dst_z (r1_z[i+1])
      );
   end

   logic [W3-1:0]         d3_data;
   logic [3:0][CW-1:0]    d3_f, d3_g;
   logic                  d3_deg;
   root_type              d3_s;

   qslerp_delay #(.W(W3), .DEPTH(CORDIC_STEPS)) u_delay_rot (
      .clock    (clock),
      .en       (adv),
      .src_data ({p_f_ff, p_g_ff, p_deg_ff, p_s_ff}),
      .dst_data (d3_data)
   );
   assign {d3_f, d3_g, d3_deg, d3_s} = d3_data;

   // weighted products, negative sines taken as zero
   logic [SINE_W-1:0]       sin0, sin1;
   logic signed [MUL_W-1:0] m_pf_ff [4];
   logic signed [MUL_W-1:0] m_pg_ff [4];
   logic [3:0][CW-1:0]      m_f_ff;
   logic                    m_deg_ff;
   root_type                m_s_ff;

   assign sin0 = r0_y[CORDIC_STEPS][XY_W-1] ? '0 : r0_y[CORDIC_STEPS][SINE_W-1:0];
   assign sin1 = r1_y[CORDIC_STEPS][XY_W-1] ? '0 : r1_y[CORDIC_STEPS][SINE_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            m_pf_ff[k] <= MUL_W'($signed(d3_f[k])) * MUL_W'($signed({1'b0, sin0}));
            m_pg_ff[k] <= MUL_W'($signed(d3_g[k])) * MUL_W'($signed({1'b0, sin1}));
         end
         m_f_ff   <= d3_f;
         m_deg_ff <= d3_deg;
         m_s_ff   <= d3_s;
      end
   end

   // numerator magnitude with half divisor for rounding
   logic signed [SUM_W-1:0] n_sum [4];
   logic [SUM_W-1:0]        n_mag [4];
   logic [3:0][NUM_W-1:0]   n_num_ff;
   logic [3:0]              n_neg_ff;
   logic [3:0][CW-1:0]      n_f_ff;
   logic                    n_deg_ff;
   root_type                n_s_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         n_sum[k] = SUM_W'(m_pf_ff[k]) + SUM_W'(m_pg_ff[k]);
         n_mag[k] = n_sum[k][SUM_W-1] ? $unsigned(-n_sum[k]) : $unsigned(n_sum[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            n_num_ff[k] <= NUM_W'(n_mag[k]) + NUM_W'(m_s_ff >> 1);
            n_neg_ff[k] <= n_sum[k][SUM_W-1];
         end
         n_f_ff   <= m_f_ff;
         n_deg_ff <= m_deg_ff;
         n_s_ff   <= m_s_ff;
      end
   end

   // quotient overflow check
   logic [3:0][NUM_W-1:0] o_num_ff;
   logic [3:0]            o_ovf_ff;
   logic [3:0]            o_neg_ff;
   logic [3:0][CW-1:0]    o_f_ff;
   logic                  o_deg_ff;
   root_type              o_s_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            o_ovf_ff[k] <= n_num_ff[k] >= (NUM_W'(n_s_ff) << CW);
         end
         o_num_ff <= n_num_ff;
         o_neg_ff <= n_neg_ff;
         o_f_ff   <= n_f_ff;
         o_deg_ff <= n_deg_ff;
         o_s_ff   <= n_s_ff;
      end
   end

   // divide row
   logic [3:0][NUM_W-1:0] dv_rem [CW+1];
   logic [3:0][CW-1:0]    dv_q   [CW+1];
   root_type              dv_s   [CW+1];

   assign dv_rem[0] = o_num_ff;
   assign dv_q[0]   = '0;
   assign dv_s[0]   = o_s_ff;

   for (genvar i = 0; i < CW; i++) begin : g_div
      qslerp_div_cell #(.COMP_W(CW), .NUM_W(NUM_W), .BIT_POS(CW - 1 - i)) u_cell (
         .clock   (clock),
         .en      (adv),
         .src_rem (dv_rem[i]),
         .src_q   (dv_q[i]),
         .src_s   (dv_s[i]),
         .dst_rem (dv_rem[i+1]),
         .dst_q   (dv_q[i+1]),
         .dst_s   (dv_s[i+1])
      );
   end

   logic [W4-1:0]         d4_data;
   logic [3:0][CW-1:0]    d4_f;
   logic                  d4_deg;
   logic [3:0]            d4_neg, d4_ovf;

   qslerp_delay #(.W(W4), .DEPTH(CW)) u_delay_div (
      .clock    (clock),
      .en       (adv),
      .src_data ({o_f_ff, o_deg_ff, o_neg_ff, o_ovf_ff}),
      .dst_data (d4_data)
   );
   assign {d4_f, d4_deg, d4_neg, d4_ovf} = d4_data;

   // saturate, or pass the start quaternion through
   logic [CW-1:0]      q_hi, q_lo;
   logic [3:0][CW-1:0] res;
   logic [3:0][CW-1:0] out_ff;
   logic               pass_ff;

   assign q_hi = {1'b0, {(CW-1){1'b1}}};
   assign q_lo = {1'b1, {(CW-1){1'b0}}};

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (d4_deg) begin
            res[k] = d4_f[k];
         end else if (d4_neg[k]) begin
            res[k] = (d4_ovf[k] || dv_q[CW][k] > q_lo) ? q_lo : CW'(-dv_q[CW][k]);
         end else begin
            res[k] = (d4_ovf[k] || dv_q[CW][k] > q_hi) ? q_hi : dv_q[CW][k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff  <= res;
         pass_ff <= d4_deg;
      end
   end

   assign rsp_out_x          = out_ff[0];
   assign rsp_out_y          = out_ff[1];
   assign rsp_out_z          = out_ff[2];
   assign rsp_out_w          = out_ff[3];
   assign rsp_passed_through = pass_ff;

endmodule
